// File: rtl/core/min_max_tracking_stack_top_defines.svh
// Assertion helpers shared by the stack modules
`ifndef MIN_MAX_TRACKING_STACK_TOP_DEFINES_SVH
`define MIN_MAX_TRACKING_STACK_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define MMTS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MMTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MMTS_ASSERT(lbl, prop, msg)
`define MMTS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: rtl/core/mmts_pkg.sv
package mmts_pkg;

    localparam int unsigned STACK_DEPTH_DEF = 16;
    localparam int unsigned DATA_W          = 32;
    localparam int unsigned ENTRY_W         = 3 * DATA_W;
    localparam int unsigned COUNT_OUT_W     = 5;
    localparam int unsigned STATUS_W        = 2;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd2;

    localparam logic [DATA_W-1:0] EMPTY_WORD = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FILL,
        S_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic fill;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_fill;
    } dp_stat_t;

endpackage

// File: rtl/core/mmts_ram.sv
module mmts_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/mmts_ctrl.sv
`include "min_max_tracking_stack_top_defines.svh"

module mmts_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output mmts_pkg::ctrl_cmd_t   ctrl,
    input  mmts_pkg::dp_stat_t    stat
);

    mmts_pkg::state_t state_reg;
    mmts_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mmts_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mmts_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = mmts_pkg::S_EXEC;
                end
            end
            mmts_pkg::S_EXEC:
            begin
                state_next = stat.need_fill ? mmts_pkg::S_FILL : mmts_pkg::S_DONE;
            end
            mmts_pkg::S_FILL:
            begin
                state_next = mmts_pkg::S_DONE;
            end
            mmts_pkg::S_DONE:
            begin
                if (slot_free)
                begin
                    state_next = mmts_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = mmts_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        ctrl      = '0;
        case (state_reg)
            mmts_pkg::S_IDLE:
            begin
                in_ready  = 1'b1;
                ctrl.load = in_valid;
            end
            mmts_pkg::S_EXEC:
            begin
                ctrl.exec = 1'b1;
            end
            mmts_pkg::S_FILL:
            begin
                ctrl.fill = 1'b1;
            end
            mmts_pkg::S_DONE:
            begin
                ctrl.emit = slot_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // result slot: set on emit, cleared when the word is taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctrl.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

    `MMTS_ASSERT_NEXT(a_accept_exec, in_valid && in_ready, state_reg == mmts_pkg::S_EXEC, "accepted word did not start execution")
    `MMTS_ASSERT_NEXT(a_emit_valid, ctrl.emit, out_valid_reg, "emitted result not presented")
    `MMTS_ASSERT(a_fill_after_exec, (state_reg == mmts_pkg::S_FILL) |-> ($past(state_reg) == mmts_pkg::S_EXEC), "refill without a pop")

endmodule

// File: rtl/core/mmts_dpath.sv
`include "min_max_tracking_stack_top_defines.svh"

module mmts_dpath #(
    parameter int unsigned STACK_DEPTH = mmts_pkg::STACK_DEPTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  mmts_pkg::ctrl_cmd_t                    ctrl,
    output mmts_pkg::dp_stat_t                     stat,
    input  logic                                   cmd,
    input  logic signed [mmts_pkg::DATA_W-1:0]     value,
    output logic [mmts_pkg::STATUS_W-1:0]          status,
    output logic signed [mmts_pkg::DATA_W-1:0]     popped_value,
    output logic signed [mmts_pkg::DATA_W-1:0]     top_value,
    output logic signed [mmts_pkg::DATA_W-1:0]     current_min,
    output logic signed [mmts_pkg::DATA_W-1:0]     current_max,
    output logic [mmts_pkg::COUNT_OUT_W-1:0]       entry_count,
    output logic                                   is_empty,
    output logic                                   is_full
);

    localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int unsigned AW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int unsigned DW    = mmts_pkg::DATA_W;

    logic                          cmd_reg;
    logic signed [DW-1:0]          value_reg;
    logic [CNT_W-1:0]              count_reg;
    logic [CNT_W-1:0]              count_next;
    logic signed [DW-1:0]          top_val_reg;
    logic signed [DW-1:0]          top_min_reg;
    logic signed [DW-1:0]          top_max_reg;
    logic [mmts_pkg::STATUS_W-1:0] op_status_reg;
    logic signed [DW-1:0]          op_popped_reg;

    logic [mmts_pkg::STATUS_W-1:0] status_reg;
    logic signed [DW-1:0]          popped_out_reg;
    logic signed [DW-1:0]          top_out_reg;
    logic signed [DW-1:0]          min_out_reg;
    logic signed [DW-1:0]          max_out_reg;
    logic [mmts_pkg::COUNT_OUT_W-1:0] count_out_reg;
    logic                          empty_out_reg;
    logic                          full_out_reg;

    logic                          full;
    logic                          empty;
    logic                          do_push;
    logic                          do_pop;
    logic [CNT_W-1:0]              cnt_m1;
    logic [CNT_W-1:0]              cnt_m2;
    logic signed [DW-1:0]          new_min;
    logic signed [DW-1:0]          new_max;
    logic [mmts_pkg::ENTRY_W-1:0]  ram_rdata;
    logic [CNT_W+mmts_pkg::COUNT_OUT_W-1:0] cnt_ext;

    assign full    = (count_reg == CNT_W'(STACK_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = ctrl.exec && (cmd_reg == mmts_pkg::CMD_PUSH) && !full;
    assign do_pop  = ctrl.exec && (cmd_reg == mmts_pkg::CMD_POP) && !empty;
    assign cnt_m1  = count_reg - CNT_W'(1);
    assign cnt_m2  = count_reg - CNT_W'(2);

    // pop leaving entries behind must fetch the new top from the RAM
    assign stat.need_fill = do_pop && (count_reg > CNT_W'(1));

    // first entry seeds the running extremes
    always_comb
    begin
        new_min = value_reg;
        new_max = value_reg;
        if (!empty)
        begin
            new_min = (value_reg < top_min_reg) ? value_reg : top_min_reg;
            new_max = (top_max_reg < value_reg) ? value_reg : top_max_reg;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (do_push)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop)
        begin
            count_next = cnt_m1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // entries below the top live in RAM; the top stays in registers
    mmts_ram #(
        .WIDTH (mmts_pkg::ENTRY_W),
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (do_push && !empty),
        .waddr (cnt_m1[AW-1:0]),
        .wdata ({top_val_reg, top_min_reg, top_max_reg}),
        .re    (stat.need_fill),
        .raddr (cnt_m2[AW-1:0]),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg   <= cmd;
            value_reg <= value;
        end
        if (ctrl.exec)
        begin
            if (cmd_reg == mmts_pkg::CMD_PUSH && full)
            begin
                op_status_reg <= mmts_pkg::STATUS_OVERFLOW;
            end
            else if (cmd_reg == mmts_pkg::CMD_POP && empty)
            begin
                op_status_reg <= mmts_pkg::STATUS_UNDERFLOW;
            end
            else
            begin
                op_status_reg <= mmts_pkg::STATUS_OK;
            end
            if (do_pop)
            begin
                op_popped_reg <= top_val_reg;
            end
            else
            begin
                op_popped_reg <= mmts_pkg::EMPTY_WORD;
            end
        end
        if (do_push)
        begin
            top_val_reg <= value_reg;
            top_min_reg <= new_min;
            top_max_reg <= new_max;
        end
        else if (ctrl.fill)
        begin
            top_val_reg <= ram_rdata[3*DW-1:2*DW];
            top_min_reg <= ram_rdata[2*DW-1:DW];
            top_max_reg <= ram_rdata[DW-1:0];
        end
    end

    assign cnt_ext = {{mmts_pkg::COUNT_OUT_W{1'b0}}, count_reg};

    always_ff @(posedge clk)
    begin
        if (ctrl.emit)
        begin
            status_reg     <= op_status_reg;
            popped_out_reg <= op_popped_reg;
            top_out_reg    <= empty ? mmts_pkg::EMPTY_WORD : top_val_reg;
            min_out_reg    <= empty ? mmts_pkg::EMPTY_WORD : top_min_reg;
            max_out_reg    <= empty ? mmts_pkg::EMPTY_WORD : top_max_reg;
            count_out_reg  <= cnt_ext[mmts_pkg::COUNT_OUT_W-1:0];
            empty_out_reg  <= empty;
            full_out_reg   <= full;
        end
    end

    assign status       = status_reg;
    assign popped_value = popped_out_reg;
    assign top_value    = top_out_reg;
    assign current_min  = min_out_reg;
    assign current_max  = max_out_reg;
    assign entry_count  = count_out_reg;
    assign is_empty     = empty_out_reg;
    assign is_full      = full_out_reg;

    `MMTS_ASSERT(a_count_bound, count_reg <= CNT_W'(STACK_DEPTH), "entry count beyond depth")
    `MMTS_ASSERT(a_fill_nonempty, ctrl.fill |-> !empty, "refill with an empty stack")

endmodule

// File: rtl/core/min_max_tracking_stack_top.sv
// Each accepted word passes through the EXEC and DONE states before its result is
// presented; a pop that leaves entries behind also passes FILL (the new top is read
// back from the stack RAM). The controller handles one word at a time, holding in
// DONE until the output slot is free, and the RAM read is registered.
// Reset (rst_n, async, active low) empties the stack; RAM contents are not cleared.
module min_max_tracking_stack_top #(
    parameter int unsigned STACK_DEPTH = mmts_pkg::STACK_DEPTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic                                   cmd,
    input  logic signed [mmts_pkg::DATA_W-1:0]     value,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [mmts_pkg::STATUS_W-1:0]          status,
    output logic signed [mmts_pkg::DATA_W-1:0]     popped_value,
    output logic signed [mmts_pkg::DATA_W-1:0]     top_value,
    output logic signed [mmts_pkg::DATA_W-1:0]     current_min,
    output logic signed [mmts_pkg::DATA_W-1:0]     current_max,
    output logic [mmts_pkg::COUNT_OUT_W-1:0]       entry_count,
    output logic                                   is_empty,
    output logic                                   is_full
);

    mmts_pkg::ctrl_cmd_t ctrl;
    mmts_pkg::dp_stat_t  stat;

    mmts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ctrl      (ctrl),
        .stat      (stat)
    );

    mmts_dpath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .stat         (stat),
        .cmd          (cmd),
        .value        (value),
        .status       (status),
        .popped_value (popped_value),
        .top_value    (top_value),
        .current_min  (current_min),
        .current_max  (current_max),
        .entry_count  (entry_count),
        .is_empty     (is_empty),
        .is_full      (is_full)
    );

endmodule

// File: verif/mmts_checker.sv
module mmts_checker #(
    parameter int unsigned STACK_DEPTH = mmts_pkg::STACK_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic                                cmd,
    input  logic signed [mmts_pkg::DATA_W-1:0]  value,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic [mmts_pkg::STATUS_W-1:0]       status,
    input  logic signed [mmts_pkg::DATA_W-1:0]  popped_value,
    input  logic signed [mmts_pkg::DATA_W-1:0]  top_value,
    input  logic signed [mmts_pkg::DATA_W-1:0]  current_min,
    input  logic signed [mmts_pkg::DATA_W-1:0]  current_max,
    input  logic [mmts_pkg::COUNT_OUT_W-1:0]    entry_count,
    input  logic                                is_empty,
    input  logic                                is_full,
    output int                                  fail_count,
    output int                                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [mmts_pkg::STATUS_W-1:0]      status;
        logic signed [mmts_pkg::DATA_W-1:0] popped;
        logic signed [mmts_pkg::DATA_W-1:0] top;
        logic signed [mmts_pkg::DATA_W-1:0] low;
        logic signed [mmts_pkg::DATA_W-1:0] high;
        logic [mmts_pkg::COUNT_OUT_W-1:0]   count;
        logic                               empty;
        logic                               full;
    } stack_view_t;

    logic signed [mmts_pkg::DATA_W-1:0] word_mem [STACK_DEPTH];
    logic signed [mmts_pkg::DATA_W-1:0] low_mem  [STACK_DEPTH];
    logic signed [mmts_pkg::DATA_W-1:0] high_mem [STACK_DEPTH];
    int unsigned                        depth;
    stack_view_t                        expected_q [$];
    int                                 errors;

    // applies one push or pop to the shadow stack and returns the view after it
    function automatic stack_view_t apply_op(logic op,
                                             logic signed [mmts_pkg::DATA_W-1:0] v);
        stack_view_t r;
        int unsigned i;
        r.status = mmts_pkg::STATUS_OK;
        r.popped = mmts_pkg::EMPTY_WORD;
        r.top    = mmts_pkg::EMPTY_WORD;
        r.low    = mmts_pkg::EMPTY_WORD;
        r.high   = mmts_pkg::EMPTY_WORD;
        if (op == mmts_pkg::CMD_PUSH)
        begin
            if (depth >= STACK_DEPTH)
            begin
                r.status = mmts_pkg::STATUS_OVERFLOW;
            end
            else
            begin
                i = depth;
                word_mem[i] = v;
                if (i == 0)
                begin
                    low_mem[i]  = v;
                    high_mem[i] = v;
                end
                else
                begin
                    low_mem[i]  = (v < low_mem[i-1])  ? v : low_mem[i-1];
                    high_mem[i] = (v > high_mem[i-1]) ? v : high_mem[i-1];
                end
                depth = i + 1;
            end
        end
        else if (depth == 0)
        begin
            r.status = mmts_pkg::STATUS_UNDERFLOW;
        end
        else
        begin
            depth    = depth - 1;
            r.popped = word_mem[depth];
        end
        if (depth != 0)
        begin
            r.top  = word_mem[depth-1];
            r.low  = low_mem[depth-1];
            r.high = high_mem[depth-1];
        end
        r.count = mmts_pkg::COUNT_OUT_W'(depth);
        r.empty = (depth == 0);
        r.full  = (depth == STACK_DEPTH);
        return r;
    endfunction

    task automatic check_field(string name, logic [mmts_pkg::DATA_W-1:0] exp_v,
                               logic [mmts_pkg::DATA_W-1:0] act_v);
        if (act_v !== exp_v)
        begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        stack_view_t e;
        if (!rst_n)
        begin
            depth = 0;
            expected_q.delete();
            errors = 0;
        end
        else
        begin
            // results first: a word accepted on this edge cannot have its result here yet
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result word with no expectation waiting");
                    errors++;
                end
                else
                begin
                    e = expected_q.pop_front();
                    check_field("status", e.status, status);
                    check_field("popped_value", e.popped, popped_value);
                    check_field("top_value", e.top, top_value);
                    check_field("current_min", e.low, current_min);
                    check_field("current_max", e.high, current_max);
                    check_field("entry_count", e.count, entry_count);
                    check_field("is_empty", e.empty, is_empty);
                    check_field("is_full", e.full, is_full);
                end
            end
            if (in_valid && in_ready)
                expected_q.push_back(apply_op(cmd, value));
        end
        fail_count <= errors;
        pending    <= expected_q.size();
    end

endmodule

// File: verif/tb_min_max_tracking_stack_top.sv
module tb_min_max_tracking_stack_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_WORDS    = 1800;
    localparam int IDLE_LIMIT = 5000;
    localparam int LONG_HOLD  = 400;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               in_valid = 1'b0;
    logic                               in_ready;
    logic                               cmd = mmts_pkg::CMD_PUSH;
    logic signed [mmts_pkg::DATA_W-1:0] value = '0;
    logic                               out_valid;
    logic                               out_ready = 1'b0;
    logic [mmts_pkg::STATUS_W-1:0]      status;
    logic signed [mmts_pkg::DATA_W-1:0] popped_value;
    logic signed [mmts_pkg::DATA_W-1:0] top_value;
    logic signed [mmts_pkg::DATA_W-1:0] current_min;
    logic signed [mmts_pkg::DATA_W-1:0] current_max;
    logic [mmts_pkg::COUNT_OUT_W-1:0]   entry_count;
    logic                               is_empty;
    logic                               is_full;
    int                                 fail_count;
    int                                 pending;
    int                                 idle_cycles = 0;
    int                                 sent = 0;

    min_max_tracking_stack_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .value        (value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .popped_value (popped_value),
        .top_value    (top_value),
        .current_min  (current_min),
        .current_max  (current_max),
        .entry_count  (entry_count),
        .is_empty     (is_empty),
        .is_full      (is_full)
    );

    mmts_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .value        (value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .popped_value (popped_value),
        .top_value    (top_value),
        .current_min  (current_min),
        .current_max  (current_max),
        .entry_count  (entry_count),
        .is_empty     (is_empty),
        .is_full      (is_full),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // gap before the next word; now and then a run of back-to-back words
    function automatic int draw_gap(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0)
        begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 14);
    endfunction

    // extremes and tiny values (equal minima and maxima) mixed with full-range noise
    function automatic logic signed [mmts_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2, 3:    return int'($urandom_range(0, 8)) - 4;
            default: return $urandom;
        endcase
    endfunction

    int send_calm = 0;

    task automatic send_word(logic op, logic signed [mmts_pkg::DATA_W-1:0] v);
        int gap;
        gap = draw_gap(send_calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= op;
        value    <= v;
        do @(posedge clk); while (!in_ready);
        sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    initial
    begin
        int push_pct;
        int phase_len;
        logic op;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(mmts_pkg::CMD_POP, 32'sh1234_5678);     // underflow on empty
        send_word(mmts_pkg::CMD_PUSH, 32'sh7FFF_FFFF);
        send_word(mmts_pkg::CMD_PUSH, 32'sh8000_0000);
        send_word(mmts_pkg::CMD_PUSH, 32'sh0000_0000);
        send_word(mmts_pkg::CMD_PUSH, -32'sd1);
        send_word(mmts_pkg::CMD_PUSH, -32'sd1);           // equal values
        send_word(mmts_pkg::CMD_PUSH, 32'sh8000_0000);
        repeat (6) send_word(mmts_pkg::CMD_POP, $urandom);
        send_word(mmts_pkg::CMD_POP, 32'sh0);             // underflow again after emptying
        send_word(mmts_pkg::CMD_PUSH, 32'sd7);
        send_word(mmts_pkg::CMD_PUSH, 32'sd7);
        send_word(mmts_pkg::CMD_POP, '1);
        send_word(mmts_pkg::CMD_POP, 32'sh0);
        drain_results();

        while (sent < N_WORDS)
        begin
            case ($urandom_range(0, 3))
                0:       push_pct = 15;
                1:       push_pct = 50;
                2:       push_pct = 85;
                default: push_pct = 95;
            endcase
            phase_len = $urandom_range(20, 80);
            repeat (phase_len)
            begin
                op = ($urandom_range(0, 99) < push_pct) ? mmts_pkg::CMD_PUSH
                                                         : mmts_pkg::CMD_POP;
                send_word(op, (op == mmts_pkg::CMD_PUSH) ? pick_value()
                                                         : $signed($urandom));
                if (sent == N_WORDS / 2)
                    drain_results();
            end
        end
        drain_results();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        int gap;
        int calm;
        int results;
        calm = 0;
        results = 0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            gap = draw_gap(calm);
            // long hold-off so the stack backs up onto the input side
            if (results == 250 || results == 1100)
                gap = LONG_HOLD;
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            results++;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

endmodule
